FILE: design/svsw_pkg.sv
// Shared types and constants for the servo sync-write framer.
// Used by svsw_pos_map and servo_sync_write_framer; depends on nothing.
package svsw_pkg;

  localparam int unsigned MaxEntries = 50;
  localparam int unsigned PosW       = 10;
  localparam int unsigned DivSteps   = PosW;
  localparam int unsigned CntW       = $clog2(DivSteps);

  localparam logic [PosW-1:0] PosFull = PosW'(1023);

  localparam logic [7:0] HdrMark   = 8'hFF;
  localparam logic [7:0] HdrBcast  = 8'hFE;
  localparam logic [7:0] HdrSyncWr = 8'h83;
  localparam logic [7:0] HdrAddr   = 8'h1E;
  localparam logic [7:0] HdrDlen   = 8'h04;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // byte slots of one entry, header slots only on a packet's first entry
  typedef enum logic [3:0] {
    B_MARK0,
    B_MARK1,
    B_BCAST,
    B_LEN,
    B_INSTR,
    B_ADDR,
    B_DLEN,
    B_ID,
    B_POS_LO,
    B_POS_HI,
    B_SPD_LO,
    B_SPD_HI,
    B_CSUM
  } byte_sel_e;

  typedef struct packed {
    logic            done;
    logic [PosW-1:0] pos;
  } pos_res_t;

endpackage

FILE: design/svsw_pos_map.sv
// Angle to servo position mapping with a serial restoring divider.
// Depends on svsw_pkg.
module svsw_pos_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  angle_i,
  input  logic signed [15:0]  range_min_i,
  input  logic signed [15:0]  range_max_i,
  output svsw_pkg::pos_res_t  res_o
);

  logic signed [16:0] num, span;
  logic               zero_pos, full_pos;
  logic [26:0]        dividend;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [svsw_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [16:0]                   rem_q, rem_d;
  logic [svsw_pkg::PosW-1:0]     quo_q, quo_d;
  logic [16:0]                   div_q, div_d;

  logic [17:0] trial, diff;
  logic        ge;

  always_comb begin
    num      = 17'(angle_i) - 17'(range_min_i);
    span     = 17'(range_max_i) - 17'(range_min_i);
    zero_pos = span[16] || (span == 17'sd0) || num[16] || (num == 17'sd0);
    full_pos = (num >= span);
    // 2*num*1023 + span, below 2^27 when 0 < num < span
    dividend = {num[15:0], 11'b0} - {10'b0, num[15:0], 1'b0} + {11'b0, span[15:0]};
  end

  always_comb begin
    trial = {rem_q, quo_q[svsw_pkg::PosW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      if (zero_pos) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else if (full_pos) begin
        quo_d  = svsw_pkg::PosFull;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = '0;
        rem_d  = dividend[26:10];
        quo_d  = dividend[9:0];
        div_d  = {span[15:0], 1'b0};
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[16:0] : trial[16:0];
      quo_d = {quo_q[svsw_pkg::PosW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == svsw_pkg::CntW'(svsw_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign res_o.done = done_q;
  assign res_o.pos  = quo_q;

endmodule

FILE: design/servo_sync_write_framer.sv
// Top level of the servo sync-write framer: entry bookkeeping, byte sequencer
// and output register. Depends on svsw_pkg and svsw_pos_map.
//
// Usage:
//   One input word per servo entry on the s_axis channel. The first word of a
//   packet carries the entry count (0 is taken as 1, above 50 saturates to 50);
//   later words of the same packet ignore it.
//   The m_axis channel carries the packet one byte per word in wire order.
//   A packet's first entry yields the 7 header bytes, every entry yields id,
//   position low/high and two zero speed bytes, and the last entry adds the
//   checksum byte, flagged by tlast.
//   Flow: after a word is accepted the position divider runs (it skips the
//   division when the angle is clamped or the span is empty), then bytes
//   leave one per cycle while the receiver takes them: up to 13 bytes.
//   s_axis_tready is high only while no entry is being worked on.
//   A stalled receiver holds the byte in the output register and pauses the
//   sequencer; nothing is dropped.
//   Reset clears the open packet: the next word starts a new packet.
module servo_sync_write_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // servo_id[7:0], angle[23:8], range_min[39:24], range_max[55:40],
  // entry_count[61:56], zero fill [63:62]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  svsw_pkg::state_e    state_q, state_d;
  svsw_pkg::byte_sel_e idx_q, idx_d;
  svsw_pkg::pos_res_t  pos_res;

  logic [5:0] entries_left_q, entries_left_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic       last_q, last_d;
  logic [7:0] id_q, id_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_valid_q, out_valid_d;

  logic       accept, load, entry_done, summed;
  logic [5:0] cnt_in, n_sat;
  logic [7:0] cur_byte;

  svsw_pos_map u_pos_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .angle_i     (s_axis_tdata[23:8]),
    .range_min_i (s_axis_tdata[39:24]),
    .range_max_i (s_axis_tdata[55:40]),
    .res_o       (pos_res)
  );

  // handshake and sequencer controls
  always_comb begin
    s_axis_tready = (state_q == svsw_pkg::ST_IDLE);
    accept        = s_axis_tvalid && s_axis_tready;
    load          = (state_q == svsw_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);
    entry_done    = ((idx_q == svsw_pkg::B_SPD_HI) && !last_q) ||
                    (idx_q == svsw_pkg::B_CSUM);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      svsw_pkg::ST_IDLE: if (accept)          state_d = svsw_pkg::ST_DIV;
      svsw_pkg::ST_DIV:  if (pos_res.done)    state_d = svsw_pkg::ST_EMIT;
      svsw_pkg::ST_EMIT: if (load && entry_done) state_d = svsw_pkg::ST_IDLE;
      default:                                state_d = svsw_pkg::ST_IDLE;
    endcase
  end

  // byte select
  always_comb begin
    unique case (idx_q)
      svsw_pkg::B_MARK0:  cur_byte = svsw_pkg::HdrMark;
      svsw_pkg::B_MARK1:  cur_byte = svsw_pkg::HdrMark;
      svsw_pkg::B_BCAST:  cur_byte = svsw_pkg::HdrBcast;
      svsw_pkg::B_LEN:    cur_byte = len_q;
      svsw_pkg::B_INSTR:  cur_byte = svsw_pkg::HdrSyncWr;
      svsw_pkg::B_ADDR:   cur_byte = svsw_pkg::HdrAddr;
      svsw_pkg::B_DLEN:   cur_byte = svsw_pkg::HdrDlen;
      svsw_pkg::B_ID:     cur_byte = id_q;
      svsw_pkg::B_POS_LO: cur_byte = pos_res.pos[7:0];
      svsw_pkg::B_POS_HI: cur_byte = 8'(pos_res.pos[svsw_pkg::PosW-1:8]);
      svsw_pkg::B_CSUM:   cur_byte = ~sum_q;
      default:            cur_byte = 8'h00;
    endcase
    summed = (idx_q != svsw_pkg::B_MARK0) && (idx_q != svsw_pkg::B_MARK1) &&
             (idx_q != svsw_pkg::B_CSUM);
  end

  // datapath and outputs
  always_comb begin
    cnt_in = s_axis_tdata[61:56];
    if (cnt_in == 6'd0) begin
      n_sat = 6'd1;
    end else if (cnt_in > 6'(svsw_pkg::MaxEntries)) begin
      n_sat = 6'(svsw_pkg::MaxEntries);
    end else begin
      n_sat = cnt_in;
    end

    entries_left_d = entries_left_q;
    len_d          = len_q;
    sum_d          = sum_q;
    last_d         = last_q;
    id_d           = id_q;
    idx_d          = idx_q;
    out_byte_d     = out_byte_q;
    out_last_d     = out_last_q;
    out_valid_d    = out_valid_q;

    if (accept) begin
      id_d = s_axis_tdata[7:0];
      if (entries_left_q == 6'd0) begin
        entries_left_d = n_sat - 6'd1;
        len_d          = ({2'b00, n_sat} << 2) + {2'b00, n_sat} + 8'd4;
        sum_d          = 8'h00;
        idx_d          = svsw_pkg::B_MARK0;
      end else begin
        entries_left_d = entries_left_q - 6'd1;
        idx_d          = svsw_pkg::B_ID;
      end
      last_d = (entries_left_d == 6'd0);
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      out_byte_d  = cur_byte;
      out_last_d  = (idx_q == svsw_pkg::B_CSUM);
      out_valid_d = 1'b1;
      if (summed) begin
        sum_d = sum_q + cur_byte;
      end
      if (!entry_done) begin
        idx_d = svsw_pkg::byte_sel_e'(idx_q + 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= svsw_pkg::ST_IDLE;
      idx_q          <= svsw_pkg::B_MARK0;
      entries_left_q <= '0;
      sum_q          <= '0;
      last_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      idx_q          <= idx_d;
      entries_left_q <= entries_left_d;
      sum_q          <= sum_d;
      last_q         <= last_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    id_q       <= id_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule
